### hw/rtl/lmlt_pkg.sv
package lmlt_pkg;

   localparam int CyclesW = 8;
   localparam int LineW = 8;
   localparam int LenW = 9;
   localparam int ClockW = 11;
   localparam int CsrIdxW = 3;
   localparam int CsrDataW = 9;

   // line where v-blank starts, and last line of the frame
   localparam logic [LineW-1:0] VISIBLE_LINES = 8'd144;
   localparam logic [LineW-1:0] LAST_LINE = 8'd153;

   typedef enum logic [1:0] {
      MODE_HBLANK = 2'd0,
      MODE_VBLANK = 2'd1,
      MODE_OAM    = 2'd2,
      MODE_VRAM   = 2'd3
   } mode_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_DISPLAY_ENABLE  = 3'd0,
      CSR_LINE_COMPARE    = 3'd1,
      CSR_IRQ_ENABLE_MASK = 3'd2,
      CSR_STAT_SOURCES    = 3'd3,
      CSR_OAM_CYCLES      = 3'd4,
      CSR_VRAM_CYCLES     = 3'd5,
      CSR_HBLANK_CYCLES   = 3'd6,
      CSR_UNUSED          = 3'd7
   } csr_idx_type;

   // irq_enable_mask bits
   localparam int IrqEnVblank = 0;
   localparam int IrqEnStat = 1;
   // status_irq_sources bits
   localparam int SrcHblank = 0;
   localparam int SrcVblank = 1;
   localparam int SrcOam = 2;
   localparam int SrcCoin = 3;

   typedef struct packed {
      logic             display_enable;
      logic [LineW-1:0] line_compare;
      logic [1:0]       irq_enable_mask;
      logic [3:0]       status_irq_sources;
      logic [LenW-1:0]  oam_scan_cycles;
      logic [LenW-1:0]  vram_read_cycles;
      logic [LenW-1:0]  hblank_cycles;
   } csr_type;

   typedef struct packed {
      mode_type         mode;
      logic [LineW-1:0] line_number;
      logic             coincidence_flag;
      logic             render_strobe;
      logic             frame_done;
      logic             vblank_irq;
      logic             status_irq;
   } rsp_type;

endpackage

### hw/rtl/lmlt_csr.sv
module lmlt_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [lmlt_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [lmlt_pkg::CsrDataW-1:0] csr_wdata,
   output lmlt_pkg::csr_type             csr
);
   import lmlt_pkg::*;

   csr_type csr_ff;
   csr_type csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_wr_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_DISPLAY_ENABLE:  csr_in.display_enable = csr_wdata[0];
            CSR_LINE_COMPARE:    csr_in.line_compare = csr_wdata[LineW-1:0];
            CSR_IRQ_ENABLE_MASK: csr_in.irq_enable_mask = csr_wdata[1:0];
            CSR_STAT_SOURCES:    csr_in.status_irq_sources = csr_wdata[3:0];
            CSR_OAM_CYCLES:      csr_in.oam_scan_cycles = csr_wdata[LenW-1:0];
            CSR_VRAM_CYCLES:     csr_in.vram_read_cycles = csr_wdata[LenW-1:0];
            CSR_HBLANK_CYCLES:   csr_in.hblank_cycles = csr_wdata[LenW-1:0];
            CSR_UNUSED:          csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.display_enable     <= 1'b1;
         csr_ff.line_compare       <= '0;
         csr_ff.irq_enable_mask    <= '0;
         csr_ff.status_irq_sources <= '0;
         csr_ff.oam_scan_cycles    <= 9'd80;
         csr_ff.vram_read_cycles   <= 9'd172;
         csr_ff.hblank_cycles      <= 9'd204;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign csr = csr_ff;

endmodule

### hw/rtl/lmlt_in_stage.sv
module lmlt_in_stage (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [lmlt_pkg::CyclesW-1:0] req_cycles,
   input  logic                         advance,
   output logic                         item_valid,
   output logic [lmlt_pkg::CyclesW-1:0] item_cycles
);
   import lmlt_pkg::*;

   logic               valid_ff;
   logic               valid_in;
   logic [CyclesW-1:0] cycles_ff;
   logic               take;

   // accept when empty or when the held item moves on this cycle
   assign req_ready = !valid_ff || advance;
   assign take = req_valid && req_ready;
   assign valid_in = take || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cycles_ff <= req_cycles;
      end
   end

   assign item_valid = valid_ff;
   assign item_cycles = cycles_ff;

endmodule

### hw/rtl/lmlt_step.sv
module lmlt_step (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step_en,
   input  logic [lmlt_pkg::CyclesW-1:0] cycles,
   input  lmlt_pkg::csr_type            csr,
   output lmlt_pkg::rsp_type            rsp
);
   import lmlt_pkg::*;

   logic [ClockW-1:0] clock_ff, clock_in;
   mode_type          mode_ff, mode_in;
   logic [LineW-1:0]  line_ff, line_in;
   mode_type          rep_ff, rep_in;
   logic              coin_ff, coin_in;

   logic [ClockW-1:0] clock_sum;
   logic [ClockW-1:0] vblank_len;
   logic [LineW:0]    line_inc;
   logic              stat_on;

   assign clock_sum = clock_ff + ClockW'(cycles);
   assign vblank_len = ClockW'(csr.hblank_cycles) + ClockW'(csr.vram_read_cycles)
                       + ClockW'(csr.oam_scan_cycles);
   assign line_inc = {1'b0, line_ff} + 9'd1;
   assign stat_on = csr.irq_enable_mask[IrqEnStat];

   always_comb begin
      clock_in = clock_ff;
      mode_in  = mode_ff;
      line_in  = line_ff;
      rep_in   = rep_ff;
      coin_in  = coin_ff;
      rsp.render_strobe = 1'b0;
      rsp.frame_done    = 1'b0;
      rsp.vblank_irq    = 1'b0;
      rsp.status_irq    = 1'b0;
      if (!csr.display_enable) begin
         // hold the reported mode, park in v-blank on line 0
         clock_in = '0;
         mode_in  = MODE_VBLANK;
         line_in  = '0;
      end else begin
         clock_in = clock_sum;
         unique case (mode_ff)
            MODE_OAM: begin
               if (clock_sum >= ClockW'(csr.oam_scan_cycles)) begin
                  mode_in  = MODE_VRAM;
                  clock_in = '0;
               end
            end
            MODE_VRAM: begin
               if (clock_sum >= ClockW'(csr.vram_read_cycles)) begin
                  mode_in  = MODE_HBLANK;
                  clock_in = '0;
                  rsp.render_strobe = 1'b1;
                  if (stat_on && csr.status_irq_sources[SrcHblank]) begin
                     rsp.status_irq = 1'b1;
                  end
                  if (line_inc == {1'b0, csr.line_compare}) begin
                     coin_in = 1'b1;
                     if (csr.status_irq_sources[SrcCoin]) begin
                        rsp.status_irq = 1'b1;
                     end
                  end else begin
                     coin_in = 1'b0;
                  end
               end
            end
            MODE_HBLANK: begin
               if (clock_sum >= ClockW'(csr.hblank_cycles)) begin
                  line_in  = line_inc[LineW-1:0];
                  clock_in = '0;
                  if (line_inc[LineW-1:0] == VISIBLE_LINES) begin
                     rsp.frame_done = 1'b1;
                     rsp.vblank_irq = csr.irq_enable_mask[IrqEnVblank];
                     if (stat_on && csr.status_irq_sources[SrcVblank]) begin
                        rsp.status_irq = 1'b1;
                     end
                     mode_in = MODE_VBLANK;
                  end else begin
                     mode_in = MODE_OAM;
                  end
               end
            end
            MODE_VBLANK: begin
               if (clock_sum >= vblank_len) begin
                  clock_in = '0;
                  if (line_inc > {1'b0, LAST_LINE}) begin
                     if (stat_on && csr.status_irq_sources[SrcOam]) begin
                        rsp.status_irq = 1'b1;
                     end
                     mode_in = MODE_OAM;
                     line_in = '0;
                  end else begin
                     line_in = line_inc[LineW-1:0];
                  end
               end
            end
         endcase
         rep_in = mode_in;
      end
      rsp.mode             = rep_in;
      rsp.line_number      = line_in;
      rsp.coincidence_flag = coin_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ff <= '0;
         mode_ff  <= MODE_HBLANK;
         line_ff  <= '0;
         rep_ff   <= MODE_HBLANK;
         coin_ff  <= 1'b0;
      end else if (step_en) begin
         clock_ff <= clock_in;
         mode_ff  <= mode_in;
         line_ff  <= line_in;
         rep_ff   <= rep_in;
         coin_ff  <= coin_in;
      end
   end

endmodule

### hw/rtl/lcd_mode_line_timer.sv
// Path: an accepted item lands in the input register, then passes once through the
//   mode/line step logic into the result register, which drives the rsp ports until
//   the result is taken.
// Throughput: one item per cycle while rsp_ready is high; both registers stay full
//   under continuous flow, as the result slot refills in the same cycle it is taken.
// Reset: synchronous, active high; clears timer state to h-blank, line 0, clock 0,
//   empties both stages and loads the register defaults (enabled, lengths 80/172/204).
module lcd_mode_line_timer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [lmlt_pkg::CyclesW-1:0]  req_cycles,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_mode,
   output logic [lmlt_pkg::LineW-1:0]    rsp_line_number,
   output logic                          rsp_coincidence_flag,
   output logic                          rsp_render_strobe,
   output logic                          rsp_frame_done,
   output logic                          rsp_vblank_irq,
   output logic                          rsp_status_irq,
   input  logic                          csr_wr_en,
   input  logic [lmlt_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [lmlt_pkg::CsrDataW-1:0] csr_wdata
);
   import lmlt_pkg::*;

   csr_type            csr;
   logic               item_valid;
   logic [CyclesW-1:0] item_cycles;
   logic               advance;
   rsp_type            step_rsp;
   rsp_type            rsp_ff;
   logic               out_valid_ff;
   logic               out_valid_in;

   // configuration registers; the user must write them only while idle, the block does not enforce it
   lmlt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr       (csr)
   );

   // input register: holds one item until the result slot can take it
   lmlt_in_stage u_in (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_cycles  (req_cycles),
      .advance     (advance),
      .item_valid  (item_valid),
      .item_cycles (item_cycles)
   );

   // advance the held item when the result slot is empty or drains this cycle;
   // timer state commits at the same edge so each item steps it exactly once
   assign advance = item_valid && (!out_valid_ff || rsp_ready);

   lmlt_step u_step (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .cycles  (item_cycles),
      .csr     (csr),
      .rsp     (step_rsp)
   );

   // result register: hold the result until taken, refill in the same cycle
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_mode             = rsp_ff.mode;
   assign rsp_line_number      = rsp_ff.line_number;
   assign rsp_coincidence_flag = rsp_ff.coincidence_flag;
   assign rsp_render_strobe    = rsp_ff.render_strobe;
   assign rsp_frame_done       = rsp_ff.frame_done;
   assign rsp_vblank_irq       = rsp_ff.vblank_irq;
   assign rsp_status_irq       = rsp_ff.status_irq;

   // a stepped item always lands in the result register
   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("stepped item did not reach the result register");

   // frame_done is reported only with v-blank on the first invisible line
   a_frame_line: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_done) |->
         (rsp_mode == MODE_VBLANK && rsp_line_number == VISIBLE_LINES))
      else $error("frame_done without v-blank entry");

   // a render strobe means VRAM read just ended into h-blank
   a_strobe_hblank: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_render_strobe) |-> (rsp_mode == MODE_HBLANK && !rsp_frame_done))
      else $error("render strobe outside h-blank entry");

   // the v-blank interrupt only accompanies v-blank entry
   a_virq_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_vblank_irq) |-> rsp_frame_done)
      else $error("v-blank interrupt without frame_done");

endmodule

### sim/lcd_mode_line_timer_checker.sv
`timescale 1ns / 1ps

module lcd_mode_line_timer_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [lmlt_pkg::CyclesW-1:0]  req_cycles,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [1:0]                    rsp_mode,
   input  logic [lmlt_pkg::LineW-1:0]    rsp_line_number,
   input  logic                          rsp_coincidence_flag,
   input  logic                          rsp_render_strobe,
   input  logic                          rsp_frame_done,
   input  logic                          rsp_vblank_irq,
   input  logic                          rsp_status_irq,
   input  logic                          csr_wr_en,
   input  logic [lmlt_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [lmlt_pkg::CsrDataW-1:0] csr_wdata,
   output int                            mismatch_count,
   output int                            reports_waiting,
   output int                            frames_seen
);
   import lmlt_pkg::*;

   // shadow copy of the register file
   logic             disp_on;
   logic [LineW-1:0] cmp_line;
   logic [1:0]       irq_mask;
   logic [3:0]       stat_src;
   logic [LenW-1:0]  oam_len;
   logic [LenW-1:0]  vram_len;
   logic [LenW-1:0]  hblank_len;

   // shadow copy of the timer state
   logic [ClockW-1:0] mclk;
   mode_type          timer_mode;
   mode_type          shown_mode;
   logic [LineW-1:0]  line_ctr;
   logic              coin_bit;

   rsp_type reports_due[$];
   rsp_type want_report;
   int      shown_errors;

   function automatic rsp_type advance_timer(input logic [CyclesW-1:0] ticks);
      rsp_type   r;
      logic      stat_on;
      logic [11:0] vblank_len;
      r = '0;
      stat_on = irq_mask[IrqEnStat];
      vblank_len = 12'(hblank_len) + 12'(vram_len) + 12'(oam_len);
      if (!disp_on) begin
         line_ctr = '0;
         mclk = '0;
         timer_mode = MODE_VBLANK;
      end else begin
         mclk = mclk + ClockW'(ticks);
         case (timer_mode)
            MODE_OAM: begin
               if (mclk >= ClockW'(oam_len)) begin
                  timer_mode = MODE_VRAM;
                  mclk = '0;
               end
            end
            MODE_VRAM: begin
               if (mclk >= ClockW'(vram_len)) begin
                  timer_mode = MODE_HBLANK;
                  mclk = '0;
                  r.render_strobe = 1'b1;
                  if (stat_on && stat_src[SrcHblank]) r.status_irq = 1'b1;
                  // next line at full width, so line 255 never matches
                  if ({1'b0, line_ctr} + 9'd1 == {1'b0, cmp_line}) begin
                     coin_bit = 1'b1;
                     if (stat_src[SrcCoin]) r.status_irq = 1'b1;
                  end else begin
                     coin_bit = 1'b0;
                  end
               end
            end
            MODE_HBLANK: begin
               if (mclk >= ClockW'(hblank_len)) begin
                  line_ctr = line_ctr + 8'd1;
                  mclk = '0;
                  if (line_ctr == VISIBLE_LINES) begin
                     r.frame_done = 1'b1;
                     if (irq_mask[IrqEnVblank]) r.vblank_irq = 1'b1;
                     if (stat_on && stat_src[SrcVblank]) r.status_irq = 1'b1;
                     timer_mode = MODE_VBLANK;
                  end else begin
                     timer_mode = MODE_OAM;
                  end
               end
            end
            default: begin
               if (12'(mclk) >= vblank_len) begin
                  mclk = '0;
                  if ({1'b0, line_ctr} + 9'd1 > {1'b0, LAST_LINE}) begin
                     if (stat_on && stat_src[SrcOam]) r.status_irq = 1'b1;
                     timer_mode = MODE_OAM;
                     line_ctr = '0;
                  end else begin
                     line_ctr = line_ctr + 8'd1;
                  end
               end
            end
         endcase
         shown_mode = timer_mode;
      end
      r.mode = shown_mode;
      r.line_number = line_ctr;
      r.coincidence_flag = coin_bit;
      return r;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         mismatch_count++;
         if (shown_errors < 40) begin
            shown_errors++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         disp_on = 1'b1;
         cmp_line = '0;
         irq_mask = '0;
         stat_src = '0;
         oam_len = 9'd80;
         vram_len = 9'd172;
         hblank_len = 9'd204;
         mclk = '0;
         timer_mode = MODE_HBLANK;
         shown_mode = MODE_HBLANK;
         line_ctr = '0;
         coin_bit = 1'b0;
         reports_due.delete();
         mismatch_count = 0;
         frames_seen = 0;
         shown_errors = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_idx_type'(csr_index))
               CSR_DISPLAY_ENABLE:  disp_on = csr_wdata[0];
               CSR_LINE_COMPARE:    cmp_line = csr_wdata[LineW-1:0];
               CSR_IRQ_ENABLE_MASK: irq_mask = csr_wdata[1:0];
               CSR_STAT_SOURCES:    stat_src = csr_wdata[3:0];
               CSR_OAM_CYCLES:      oam_len = csr_wdata[LenW-1:0];
               CSR_VRAM_CYCLES:     vram_len = csr_wdata[LenW-1:0];
               CSR_HBLANK_CYCLES:   hblank_len = csr_wdata[LenW-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (reports_due.size() == 0) begin
               mismatch_count++;
               $display("%0t: result with none expected, mode %0d line %0d", $time,
                        rsp_mode, rsp_line_number);
            end else begin
               want_report = reports_due.pop_front();
               if (want_report.frame_done) frames_seen++;
               check_field("mode", want_report.mode, rsp_mode);
               check_field("line_number", want_report.line_number, rsp_line_number);
               check_field("coincidence_flag", want_report.coincidence_flag,
                           rsp_coincidence_flag);
               check_field("render_strobe", want_report.render_strobe, rsp_render_strobe);
               check_field("frame_done", want_report.frame_done, rsp_frame_done);
               check_field("vblank_irq", want_report.vblank_irq, rsp_vblank_irq);
               check_field("status_irq", want_report.status_irq, rsp_status_irq);
            end
         end
         if (req_valid && req_ready) reports_due.push_back(advance_timer(req_cycles));
      end
      reports_waiting = reports_due.size();
   end

endmodule

### sim/lcd_mode_line_timer_tb.sv
`timescale 1ns / 1ps

module lcd_mode_line_timer_tb;
   import lmlt_pkg::*;

   localparam int CycleLimit = 200000;

   // every block input starts at a known value
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic [CyclesW-1:0]  req_cycles = '0;
   logic                rsp_ready = 1'b0;
   logic                csr_wr_en = 1'b0;
   logic [CsrIdxW-1:0]  csr_index = '0;
   logic [CsrDataW-1:0] csr_wdata = '0;

   logic               req_ready;
   logic               rsp_valid;
   logic [1:0]         rsp_mode;
   logic [LineW-1:0]   rsp_line_number;
   logic               rsp_coincidence_flag;
   logic               rsp_render_strobe;
   logic               rsp_frame_done;
   logic               rsp_vblank_irq;
   logic               rsp_status_irq;

   int mismatch_count;
   int reports_waiting;
   int frames_seen;

   int cycle_count = 0;
   int items_sent = 0;
   int settings_used = 0;
   bit steady = 1'b0;     // suppress random idling on both sides
   int hold_asks = 0;     // bumped by the stimulus to ask for a long result stall
   int hold_served = 0;
   int hold_left = 0;

   logic [7:0] opening_ticks [9] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255,
                                     8'd1, 8'd128};

   always #10 clock = ~clock;

   lcd_mode_line_timer uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_cycles           (req_cycles),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_mode             (rsp_mode),
      .rsp_line_number      (rsp_line_number),
      .rsp_coincidence_flag (rsp_coincidence_flag),
      .rsp_render_strobe    (rsp_render_strobe),
      .rsp_frame_done       (rsp_frame_done),
      .rsp_vblank_irq       (rsp_vblank_irq),
      .rsp_status_irq       (rsp_status_irq),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   lcd_mode_line_timer_checker timer_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_cycles           (req_cycles),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_mode             (rsp_mode),
      .rsp_line_number      (rsp_line_number),
      .rsp_coincidence_flag (rsp_coincidence_flag),
      .rsp_render_strobe    (rsp_render_strobe),
      .rsp_frame_done       (rsp_frame_done),
      .rsp_vblank_irq       (rsp_vblank_irq),
      .rsp_status_irq       (rsp_status_irq),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .mismatch_count       (mismatch_count),
      .reports_waiting      (reports_waiting),
      .frames_seen          (frames_seen)
   );

   // Result side: drop ready at random, or for a long counted stretch when asked.
   always @(negedge clock) begin
      if (hold_asks != hold_served) begin
         hold_served = hold_asks;
         hold_left = 90;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 99) < 17) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("run stopped at cycle limit, %0d results still due", reports_waiting);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Offer one item carrying a tick count; called just after a falling edge, returns just after one.
   // Valid is left high so a following item goes out without a gap.
   task automatic offer(input logic [CyclesW-1:0] ticks);
      while (!steady && $urandom_range(0, 99) < 17) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cycles <= ticks;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      items_sent++;
   endtask

   // Drop valid and hold until every expected result is back.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (reports_waiting != 0);
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [CsrDataW-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   // Load the whole register file; only call while the block is idle.
   task automatic apply_settings(input logic enable, input logic [LineW-1:0] compare,
                                 input logic [1:0] mask, input logic [3:0] sources,
                                 input logic [LenW-1:0] oam, input logic [LenW-1:0] vram,
                                 input logic [LenW-1:0] hblank);
      write_reg(CSR_DISPLAY_ENABLE, CsrDataW'(enable));
      write_reg(CSR_LINE_COMPARE, CsrDataW'(compare));
      write_reg(CSR_IRQ_ENABLE_MASK, CsrDataW'(mask));
      write_reg(CSR_STAT_SOURCES, CsrDataW'(sources));
      write_reg(CSR_OAM_CYCLES, oam);
      write_reg(CSR_VRAM_CYCLES, vram);
      write_reg(CSR_HBLANK_CYCLES, hblank);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   // Mostly short ticks so modes take a few items, with full range and extremes mixed in.
   function automatic logic [CyclesW-1:0] pick_ticks();
      case ($urandom_range(0, 9))
         0:       return 8'd255;
         1:       return 8'd0;
         2, 3, 4: return 8'($urandom_range(0, 255));
         default: return 8'($urandom_range(0, 15));
      endcase
   endfunction

   // Bias the compare line toward lines the counter actually reaches.
   function automatic logic [LineW-1:0] pick_compare();
      if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(0, 155));
   endfunction

   function automatic logic [LenW-1:0] short_len();
      return 9'($urandom_range(0, 12));
   endfunction

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset defaults: zero and full ticks walk from the h-blank of line 0 into the modes of the next lines.
      foreach (opening_ticks[i]) offer(opening_ticks[i]);

      // Display off: line and clock forced, reported mode held, no pulses.
      drain_results();
      apply_settings(1'b0, 8'd0, 2'd0, 4'd0, 9'd80, 9'd172, 9'd204);
      offer(8'd255);
      offer(8'd0);
      offer(8'd77);

      // Back on with zero-length modes and every interrupt source enabled.
      drain_results();
      apply_settings(1'b1, 8'd0, 2'd3, 4'hf, 9'd0, 9'd0, 9'd0);
      repeat (8) offer(8'd0);
      offer(8'd255);

      // Index with no register behind it must be ignored.
      drain_results();
      write_reg(CSR_UNUSED, 9'($urandom_range(0, 511)));
      csr_wr_en <= 1'b0;

      // Random phases, each with its own register setting.
      for (int p = 0; p < 8; p++) begin
         drain_results();
         case (p)
            0: apply_settings(1'b1, 8'd255, 2'd3, 4'hf, 9'd511, 9'd511, 9'd511);
            1: apply_settings(1'b1, pick_compare(), 2'($urandom_range(0, 3)),
                              4'($urandom_range(0, 15)), 9'($urandom_range(1, 511)),
                              9'($urandom_range(1, 511)), 9'($urandom_range(1, 511)));
            3: apply_settings(1'b0, pick_compare(), 2'($urandom_range(0, 3)),
                              4'($urandom_range(0, 15)), short_len(), short_len(),
                              short_len());
            default: apply_settings(1'b1, pick_compare(), 2'($urandom_range(0, 3)),
                                    4'($urandom_range(0, 15)), short_len(), short_len(),
                                    short_len());
         endcase
         steady = (p == 5);
         for (int i = 0; i < ((p == 3) ? 20 : 220); i++) begin
            // stall results long enough that the block backs up into its input
            if (p == 2 && i == 60) hold_asks++;
            // pause the sender until the block has emptied
            if (p == 4 && i == 100) drain_results();
            offer(pick_ticks());
         end
      end
      steady = 1'b0;

      drain_results();
      repeat (8) @(negedge clock);
      $display("covered %0d ticks under %0d register settings, %0d frames reached v-blank",
               items_sent, settings_used, frames_seen);
      $display("included display off and back on, zero and maximum mode lengths, stalls");
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/lmlt_pkg.sv
hw/rtl/lmlt_csr.sv
hw/rtl/lmlt_in_stage.sv
hw/rtl/lmlt_step.sv
hw/rtl/lcd_mode_line_timer.sv
sim/lcd_mode_line_timer_checker.sv
sim/lcd_mode_line_timer_tb.sv
